### src/stnll_pkg.sv
// Shared types, constants and the ln(1+x) table for the Student-t NLL accumulator.
// No dependencies.
package stnll_pkg;

    localparam int MAX_SAMPLES    = 65536;
    localparam int LOG_TABLE_BITS = 8;
    localparam int CNT_W          = $clog2(MAX_SAMPLES + 1);
    localparam int FRAC_SHIFT     = 30 - LOG_TABLE_BITS;
    localparam int ROM_DEPTH      = (1 << LOG_TABLE_BITS) + 1;
    localparam int IDX_W          = $clog2(ROM_DEPTH);
    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    localparam logic [1:0] REG_DOF       = 2'd0;
    localparam logic [1:0] REG_LOCATION  = 2'd1;
    localparam logic [1:0] REG_INV_SCALE = 2'd2;
    localparam logic [1:0] REG_CONST     = 2'd3;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] nll_value;
        logic [16:0]        sample_count;
        logic               saturated;
    } out_word_t;

    // Word handed from front to back: one log term.
    typedef struct packed {
        logic signed [47:0] term;
        logic               sat;
        logic               skip;
        logic               last;
    } term_t;

    // Unsigned long division by shift and subtract; elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= 65'(den))
            begin
                r    = r - 65'(den);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/2^LOG_TABLE_BITS) in Q2.30; evaluated at elaboration.
    function automatic logic [31:0] rom_ln1p(input logic [IDX_W-1:0] i);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] term;
        logic [63:0] acc;
        x    = 64'(i) << FRAC_SHIFT;
        y    = udiv64(x << 30, (64'd1 << 31) + x);
        y2   = (y * y) >> 30;
        term = y;
        acc  = '0;
        for (int n = 1; n <= 49; n += 2)
        begin
            acc  = acc + udiv64(term, 64'(n));
            term = (term * y2) >> 30;
        end
        return 32'(acc * 64'd2);
    endfunction

    typedef logic [31:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            r[i] = rom_ln1p(IDX_W'(i));
        end
        return r;
    endfunction

    localparam rom_t LN_ROM = build_rom();

endpackage

### src/stnll_if.sv
// Valid/ready channel interface carrying one packed word.
// Depends on nothing; payload type given per instance.
interface stnll_if #(parameter type word_t = logic) (input logic clk);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/stnll_front.sv
// Front: computes t, w, ln(w) and the k*ln(w) term per sample over sequenced states.
// Depends on stnll_pkg.
module stnll_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  stnll_pkg::in_word_t       in_data,
    input  logic [24:0]               dof,
    input  logic signed [31:0]        location,
    input  logic [31:0]               inv_scale,
    output logic                      out_valid,
    input  logic                      out_ready,
    output stnll_pkg::term_t          out_data
);
    import stnll_pkg::*;

    // State register; one sample in flight at a time, stepped through the states in order.
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQR, S_LOG, S_TERM, S_OUT} st_t;
    st_t st_reg;

    logic [31:0] mag_reg;
    logic        sat_reg;
    logic        last_reg;
    logic [63:0] prod_reg;
    logic [47:0] w_reg;
    logic signed [31:0] ln_reg;
    term_t       out_reg;

    // difference with saturation
    logic signed [32:0] d;
    logic [31:0]        dmag;
    logic               dsat;
    always_comb
    begin
        d    = 33'(in_data.sample) - 33'(location);
        dsat = 1'b0;
        if (d > 33'sd2147483647)
        begin
            d = 33'sd2147483647;
            dsat = 1'b1;
        end
        else if (d < -33'sd2147483648)
        begin
            d = -33'sd2147483648;
            dsat = 1'b1;
        end
        dmag = d[32] ? 32'(-d) : 32'(d);
    end

    // |t| after rounding and clamping
    logic [47:0] t_full;
    logic [30:0] t_val;
    logic        t_sat;
    always_comb
    begin
        t_full = 48'((prod_reg + 64'd32768) >> 16);
        t_sat  = (t_full > 48'd2147483647);
        t_val  = t_sat ? 31'h7FFF_FFFF : t_full[30:0];
    end

    // ln(w): leading one, table lookup and interpolation
    logic [5:0]        p;
    logic [47:0]       wn;
    logic [29:0]       frac;
    logic [IDX_W-1:0]  idx;
    logic [FRAC_SHIFT-1:0] rem;
    logic [31:0]       lo;
    logic [31:0]       hi;
    logic [63:0]       v;
    logic [63:0]       lnr;
    logic [47:0]       wsh;
    always_comb
    begin
        wn = (w_reg == '0) ? 48'd1 : w_reg;
        p  = '0;
        for (int i = 0; i <= 46; i++)
        begin
            if (wn[i])
            begin
                p = 6'(i);
            end
        end
        wsh  = wn ^ (48'd1 << p);
        if (p >= 6'd30)
        begin
            wsh = wsh >> (p - 6'd30);
        end
        else
        begin
            wsh = wsh << (6'd30 - p);
        end
        frac = wsh[29:0];
        idx  = IDX_W'(frac >> FRAC_SHIFT);
        rem  = frac[FRAC_SHIFT-1:0];
        lo   = LN_ROM[idx];
        hi   = LN_ROM[idx + 1'b1];
        v    = 64'($signed({1'b0, p}) - 7'sd16) * 64'(signed'({1'b0, LN2_Q30}))
               + 64'(lo) + 64'((64'(hi - lo) * 64'(rem)) >> FRAC_SHIFT);
        lnr  = ((v + (64'd1 << 35) + 64'd8192) >> 14) - (64'd1 << 21);
    end

    logic [31:0] ln_abs;
    logic [57:0] kprod;
    logic [47:0] kterm;
    always_comb
    begin
        ln_abs = ln_reg[31] ? 32'(-ln_reg) : 32'(ln_reg);
        kprod  = 58'((26'(dof) + 26'd65536) * 58'(ln_abs));
        kterm  = 48'((kprod + 58'd65536) >> 17);
    end

    assign in_ready  = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mag_reg  <= dmag;
                        sat_reg  <= dsat;
                        last_reg <= in_data.last;
                        st_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= 64'(mag_reg) * 64'(inv_scale);
                    st_reg   <= S_SQR;
                end
                S_SQR:
                begin
                    sat_reg <= sat_reg | t_sat;
                    w_reg   <= 48'(25'(dof)) + 48'((62'(t_val) * 62'(t_val) + 62'd32768) >> 16);
                    st_reg  <= S_LOG;
                end
                S_LOG:
                begin
                    ln_reg <= 32'(lnr);
                    st_reg <= S_TERM;
                end
                S_TERM:
                begin
                    out_reg.term <= ln_reg[31] ? -$signed(kterm) : $signed(kterm);
                    out_reg.sat  <= sat_reg;
                    out_reg.skip <= 1'b0;
                    out_reg.last <= last_reg;
                    st_reg       <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### src/stnll_queue.sv
// Two-entry queue of term words between front and back.
// Depends on stnll_pkg.
module stnll_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  stnll_pkg::term_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output stnll_pkg::term_t out_data
);
    import stnll_pkg::*;

    term_t     mem_reg [2];
    logic      wp_reg;
    logic      rp_reg;
    logic [1:0] cnt_reg;
    logic      push;
    logic      pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### src/stnll_back.sv
// Back: accumulates terms, counts samples, forms the final NLL word.
// Depends on stnll_pkg.
module stnll_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  stnll_pkg::term_t   in_data,
    input  logic signed [31:0] const_term,
    output logic               out_valid,
    input  logic               out_ready,
    output stnll_pkg::out_word_t out_data
);
    import stnll_pkg::*;

    typedef enum logic [1:0] {B_ACC, B_MUL, B_FIN} st_t;
    st_t st_reg;

    logic signed [47:0] sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               flag_reg;
    logic signed [63:0] cprod_reg;
    out_word_t          out_reg;
    logic               out_valid_reg;

    logic signed [48:0] s;
    logic signed [47:0] s_cl;
    logic               s_hit;
    logic               full;
    logic signed [48:0] acc_sum;
    logic [CNT_W-1:0]   acc_cnt;
    logic               acc_flag;
    always_comb
    begin
        full  = (cnt_reg == CNT_W'(MAX_SAMPLES));
        s     = 49'(sum_reg) + 49'(in_data.term);
        s_hit = (s > 49'(SUM_MAX)) || (s < 49'(SUM_MIN));
        s_cl  = (s > 49'(SUM_MAX)) ? SUM_MAX : ((s < 49'(SUM_MIN)) ? SUM_MIN : s[47:0]);
        acc_sum  = 49'(sum_reg);
        acc_cnt  = cnt_reg;
        acc_flag = flag_reg;
        if (full)
        begin
            acc_flag = 1'b1;
        end
        else
        begin
            acc_sum  = 49'(s_cl);
            acc_cnt  = cnt_reg + 1'b1;
            acc_flag = flag_reg | in_data.sat | s_hit;
        end
    end

    logic signed [64:0] fin;
    logic               f_hit;
    always_comb
    begin
        fin   = 65'(sum_reg) - 65'(cprod_reg);
        f_hit = (fin > 65'(SUM_MAX)) || (fin < 65'(SUM_MIN));
    end

    // a waiting result only holds the back when the next result is due
    assign in_ready  = (st_reg == B_ACC);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_ACC;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (st_reg != B_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                B_ACC:
                begin
                    if (in_valid && in_ready)
                    begin
                        sum_reg  <= acc_sum[47:0];
                        cnt_reg  <= acc_cnt;
                        flag_reg <= acc_flag;
                        if (in_data.last)
                        begin
                            st_reg <= B_MUL;
                        end
                    end
                end
                B_MUL:
                begin
                    cprod_reg <= 64'(const_term) * 64'($signed({1'b0, cnt_reg}));
                    st_reg    <= B_FIN;
                end
                B_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.nll_value <= (fin > 65'(SUM_MAX)) ? SUM_MAX :
                                             ((fin < 65'(SUM_MIN)) ? SUM_MIN : fin[47:0]);
                        out_reg.sample_count <= 17'(cnt_reg);
                        out_reg.saturated    <= flag_reg | f_hit;
                        out_valid_reg <= 1'b1;
                        sum_reg  <= '0;
                        cnt_reg  <= '0;
                        flag_reg <= 1'b0;
                        st_reg   <= B_ACC;
                    end
                end
                default: st_reg <= B_ACC;
            endcase
        end
    end
endmodule

### src/student_t_nll_accumulator.sv
// Top level of the Student-t NLL accumulator: config registers, front, queue, back.
// Depends on stnll_pkg, stnll_if, stnll_front, stnll_queue, stnll_back.
//
//   channel   dir   payload
//   in_ch     sink  sample[31:0] signed Q16.16, last
//   out_ch    src   nll_value[47:0], sample_count[16:0], saturated
//   cfg_*     in    write enable, 2-bit index, 32-bit data
//
// The front takes a new word only after handing off the last one
// (difference, multiply, square, log, scale, hand-off); its serial
// multiply/log chain sets the rate. The back adds each accepted term;
// a last word then takes B_MUL (const_term*count) and B_FIN (final clamp).
// rst_n clears all control state and the registers to their defaults.
// A stalled output holds the back only when the next result is ready to
// go out; the two-word queue lets the front run on.
module student_t_nll_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    stnll_if.sink       in_ch,
    stnll_if.source     out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import stnll_pkg::*;

    logic [24:0]        dof_reg;
    logic signed [31:0] location_reg;
    logic [31:0]        inv_scale_reg;
    logic signed [31:0] const_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dof_reg       <= 25'd327680;
            location_reg  <= '0;
            inv_scale_reg <= 32'd65536;
            const_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DOF:       dof_reg       <= cfg_data[24:0];
                REG_LOCATION:  location_reg  <= cfg_data;
                REG_INV_SCALE: inv_scale_reg <= cfg_data;
                REG_CONST:     const_reg     <= cfg_data;
                default:       dof_reg       <= dof_reg;
            endcase
        end
    end

    // front -> queue -> back
    logic  f_valid;
    logic  f_ready;
    term_t f_data;
    logic  q_valid;
    logic  q_ready;
    term_t q_data;

    stnll_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .dof       (dof_reg),
        .location  (location_reg),
        .inv_scale (inv_scale_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    stnll_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    stnll_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_data    (q_data),
        .const_term (const_reg),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_ch.data)
    );
endmodule
